// ----- hw/rtl/prht_pkg.sv -----
// Shared action codes, constants and controller/datapath handshake types.
package prht_pkg;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_TICK   = 2'd3
  } prht_action_t;

  // 1.0 in Q3.12
  localparam int ONE_Q12 = 4096;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;     // latch the incoming transaction
    logic add_read;   // read the top of the free stack
    logic add_write;  // store the new entry or flag the rejection
    logic scan_step;  // advance the table scan by one entry
    logic finish;     // apply the final hover update and load the result
  } prht_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_done;  // last entry compared this cycle
    logic out_free;   // result register can take a new transaction
  } prht_sts_t;

endpackage

// ----- hw/rtl/prht_if.sv -----
// Valid/ready channel interfaces for the input and result transactions.
interface prht_in_if #(
  parameter int KEY_BITS   = 8,
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   action;
  logic [KEY_BITS-1:0]          rect_id;
  logic signed [COORD_BITS-1:0] rect_left;
  logic signed [COORD_BITS-1:0] rect_top;
  logic signed [COORD_BITS-1:0] rect_width;
  logic signed [COORD_BITS-1:0] rect_height;
  logic signed [COORD_BITS-1:0] cursor_x;
  logic signed [COORD_BITS-1:0] cursor_y;
  logic                         window_focused;

  modport source (
    output valid, action, rect_id, rect_left, rect_top, rect_width, rect_height,
           cursor_x, cursor_y, window_focused,
    input  ready
  );
  modport sink (
    input  valid, action, rect_id, rect_left, rect_top, rect_width, rect_height,
           cursor_x, cursor_y, window_focused,
    output ready
  );
endinterface

interface prht_out_if #(
  parameter int KEY_BITS = 8
);
  logic                valid;
  logic                ready;
  logic                hover_valid;
  logic [KEY_BITS-1:0] hover_id;
  logic                add_rejected;

  modport source (
    output valid, hover_valid, hover_id, add_rejected,
    input  ready
  );
  modport sink (
    input  valid, hover_valid, hover_id, add_rejected,
    output ready
  );
endinterface

// ----- hw/rtl/priority_rect_hit_table.sv -----
// Top level of the priority rectangle hit table: controller, datapath and checks.
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+-------------------------------------------------
//  in_ch    | in  | valid / ready   | action, rect_id, rect_left/top/width/height,
//           |     |                 | cursor_x, cursor_y, window_focused
//  out_ch   | out | valid / ready   | hover_valid, hover_id, add_rejected
//
//  One transaction at a time. An add reads the top of the free stack and then writes
//  the entry; a clear goes straight to the result; a remove or tick scans the table,
//  reading one entry per cycle from the single read port of the entry memory. The
//  controller is back in idle as the result register loads, ready for the next one.
//  Reset (rst_n low, synchronous) empties the table, free stack and hover; entry
//  storage is not cleared. A result waiting on out_ch.ready stalls only the next
//  transaction's final step.
module priority_rect_hit_table #(
  parameter int TABLE_DEPTH   = 16,
  parameter int KEY_BITS      = 8,
  parameter int PRIORITY_BITS = 32,
  parameter int COORD_BITS    = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  prht_in_if.sink    in_ch,
  prht_out_if.source out_ch
);
  import prht_pkg::*;

  prht_cmd_t cmd;
  prht_sts_t sts;

  prht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_action (in_ch.action),
    .sts       (sts),
    .cmd       (cmd)
  );

  prht_dp #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .KEY_BITS      (KEY_BITS),
    .PRIORITY_BITS (PRIORITY_BITS),
    .COORD_BITS    (COORD_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_action         (in_ch.action),
    .in_rect_id        (in_ch.rect_id),
    .in_rect_left      (in_ch.rect_left),
    .in_rect_top       (in_ch.rect_top),
    .in_rect_width     (in_ch.rect_width),
    .in_rect_height    (in_ch.rect_height),
    .in_cursor_x       (in_ch.cursor_x),
    .in_cursor_y       (in_ch.cursor_y),
    .in_window_focused (in_ch.window_focused),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_hover_valid   (out_ch.hover_valid),
    .out_hover_id      (out_ch.hover_id),
    .out_add_rejected  (out_ch.add_rejected)
  );

`ifndef SYNTHESIS
  // never load a result over one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_ch.valid || out_ch.ready))
    else $error("result register overwritten");

  // at most one datapath phase command per cycle
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.add_read, cmd.add_write, cmd.scan_step, cmd.finish}))
    else $error("conflicting datapath commands");

  // one transaction in flight: no acceptance right after another
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second transaction accepted while busy");

  // no hover id without a hover
  a_hover_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.hover_valid) |-> (out_ch.hover_id == '0))
    else $error("hover id set without hover");
`endif

endmodule

// ----- hw/rtl/prht_ctrl.sv -----
// Controller state machine: sequences add, scan and result phases per transaction.
module prht_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_action,
  input  prht_pkg::prht_sts_t   sts,
  output prht_pkg::prht_cmd_t   cmd
);
  import prht_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_ADD_RD = 5'b00010,
    S_ADD_WR = 5'b00100,
    S_SCAN   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Decode state into commands and pick the next state
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (prht_action_t'(in_action))
            ACT_ADD:    state_nxt = S_ADD_RD;
            ACT_REMOVE: state_nxt = S_SCAN;
            ACT_TICK:   state_nxt = S_SCAN;
            ACT_CLEAR:  state_nxt = S_DONE;
          endcase
        end
      end
      S_ADD_RD: begin
        cmd.add_read = 1'b1;
        state_nxt    = S_ADD_WR;
      end
      S_ADD_WR: begin
        cmd.add_write = 1'b1;
        state_nxt     = S_DONE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the result register is free
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hw/rtl/prht_dp.sv -----
// Datapath: entry and free-stack memories, scan compare, hover and result registers.
module prht_dp #(
  parameter int TABLE_DEPTH   = 16,
  parameter int KEY_BITS      = 8,
  parameter int PRIORITY_BITS = 32,
  parameter int COORD_BITS    = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  prht_pkg::prht_cmd_t          cmd,
  output prht_pkg::prht_sts_t          sts,
  input  logic [1:0]                   in_action,
  input  logic [KEY_BITS-1:0]          in_rect_id,
  input  logic signed [COORD_BITS-1:0] in_rect_left,
  input  logic signed [COORD_BITS-1:0] in_rect_top,
  input  logic signed [COORD_BITS-1:0] in_rect_width,
  input  logic signed [COORD_BITS-1:0] in_rect_height,
  input  logic signed [COORD_BITS-1:0] in_cursor_x,
  input  logic signed [COORD_BITS-1:0] in_cursor_y,
  input  logic                         in_window_focused,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic                         out_hover_valid,
  output logic [KEY_BITS-1:0]          out_hover_id,
  output logic                         out_add_rejected
);
  import prht_pkg::*;

  localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int EXT_W  = COORD_BITS + 16;
  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(TABLE_DEPTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_DEPTH - 1);
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [EXT_W-1:0] ONE_EXT = EXT_W'(ONE_Q12);
  localparam logic signed [EXT_W-1:0] NEG_ONE_EXT = -ONE_EXT;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] left;
    logic signed [COORD_BITS-1:0] top;
    logic signed [COORD_BITS-1:0] right;
    logic signed [COORD_BITS-1:0] bottom;
    logic [PRIORITY_BITS-1:0]     prio;
    logic [KEY_BITS-1:0]          key;
  } entry_t;

  // Saturate a sum carrying one guard bit into the coordinate range
  function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic [COORD_BITS:0] s);
    logic signed [COORD_BITS-1:0] r;
    if (s[COORD_BITS] != s[COORD_BITS-1]) begin
      r = s[COORD_BITS] ? COORD_MIN : COORD_MAX;
    end else begin
      r = s[COORD_BITS-1:0];
    end
    return r;
  endfunction

  // Latched transaction
  prht_action_t                 act_r;
  logic [KEY_BITS-1:0]          id_r;
  logic signed [COORD_BITS-1:0] left_r;
  logic signed [COORD_BITS-1:0] top_r;
  logic signed [COORD_BITS-1:0] width_r;
  logic signed [COORD_BITS-1:0] height_r;
  logic signed [COORD_BITS-1:0] cx_r;
  logic signed [COORD_BITS-1:0] cy_r;
  logic                         focus_r;

  // Table bookkeeping
  logic [TABLE_DEPTH-1:0]   active_r;
  logic [CNT_W-1:0]         slots_used_r;
  logic [CNT_W-1:0]         stk_cnt_r;
  logic [PRIORITY_BITS-1:0] next_prio_r;
  logic                     hov_flag_r;
  logic [KEY_BITS-1:0]      hov_key_r;
  logic                     hov_flag_nxt;
  logic [KEY_BITS-1:0]      hov_key_nxt;

  // Scan pipeline
  logic [CNT_W-1:0]         scan_idx_r;
  logic                     cmp_valid_r;
  logic [SLOT_W-1:0]        cmp_idx_r;
  logic                     found_r;
  logic [PRIORITY_BITS-1:0] best_prio_r;
  logic [KEY_BITS-1:0]      best_key_r;
  logic                     removed_r;
  logic                     rej_r;

  // Result register
  logic                out_valid_r;
  logic                out_hover_valid_r;
  logic [KEY_BITS-1:0] out_hover_id_r;
  logic                out_add_rejected_r;

  // Memories
  entry_t            ent_mem [TABLE_DEPTH];
  entry_t            ent_rd_r;
  logic [SLOT_W-1:0] stk_mem [TABLE_DEPTH];
  logic [SLOT_W-1:0] stk_rd_r;

  logic              stack_empty;
  logic              table_full;
  logic [SLOT_W-1:0] add_slot;
  logic              ent_we;
  entry_t            ent_wd;
  logic [SLOT_W-1:0] ent_ra;
  logic [SLOT_W-1:0] stk_ra;
  logic              stk_we;
  logic              issue;
  logic              cmp_on;
  logic              act_bit;
  logic              contain;
  logic              rm_hit;
  logic              hit;
  logic              in_range;
  logic signed [EXT_W-1:0] cx_ext;
  logic signed [EXT_W-1:0] cy_ext;

  // Latch the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r    <= prht_action_t'(in_action);
      id_r     <= in_rect_id;
      left_r   <= in_rect_left;
      top_r    <= in_rect_top;
      width_r  <= in_rect_width;
      height_r <= in_rect_height;
      cx_r     <= in_cursor_x;
      cy_r     <= in_cursor_y;
      focus_r  <= in_window_focused;
    end
  end

  // Slot choice for an add: pop the free stack, else take the next fresh slot
  assign stack_empty = (stk_cnt_r == '0);
  assign table_full  = stack_empty && (slots_used_r == DEPTH_CNT);
  assign add_slot    = stack_empty ? slots_used_r[SLOT_W-1:0] : stk_rd_r;
  assign stk_ra      = SLOT_W'(stk_cnt_r - CNT_W'(1));

  // Build the new entry with saturated far edges
  always_comb begin
    ent_wd.left   = left_r;
    ent_wd.top    = top_r;
    ent_wd.right  = sat_coord({left_r[COORD_BITS-1], left_r} +
                              {width_r[COORD_BITS-1], width_r});
    ent_wd.bottom = sat_coord({top_r[COORD_BITS-1], top_r} -
                              {height_r[COORD_BITS-1], height_r});
    ent_wd.prio   = next_prio_r;
    ent_wd.key    = id_r;
  end
  assign ent_we = cmd.add_write && !table_full;

  // Scan: issue one read a cycle, compare the entry read the cycle before
  assign issue   = cmd.scan_step && (scan_idx_r < DEPTH_CNT);
  assign ent_ra  = scan_idx_r[SLOT_W-1:0];
  assign cmp_on  = cmd.scan_step && cmp_valid_r;
  assign act_bit = active_r[cmp_idx_r];
  assign contain = (cx_r >= ent_rd_r.left) && (cx_r <= ent_rd_r.right) &&
                   (cy_r <= ent_rd_r.top) && (cy_r >= ent_rd_r.bottom);
  assign rm_hit  = cmp_on && (act_r == ACT_REMOVE) && act_bit && (ent_rd_r.key == id_r);
  assign hit     = cmp_on && (act_r == ACT_TICK) && act_bit && (ent_rd_r.key != '0) &&
                   contain && (!found_r || (ent_rd_r.prio > best_prio_r));
  assign stk_we  = rm_hit && (stk_cnt_r < DEPTH_CNT);

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[add_slot] <= ent_wd;
    end
    ent_rd_r <= ent_mem[ent_ra];
  end

  // Free-slot stack memory
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_cnt_r[SLOT_W-1:0]] <= cmp_idx_r;
    end
    if (cmd.add_read) begin
      stk_rd_r <= stk_mem[stk_ra];
    end
  end

  // Cursor window check against plus and minus one
  assign cx_ext   = {{16{cx_r[COORD_BITS-1]}}, cx_r};
  assign cy_ext   = {{16{cy_r[COORD_BITS-1]}}, cy_r};
  assign in_range = (cx_ext >= NEG_ONE_EXT) && (cx_ext <= ONE_EXT) &&
                    (cy_ext >= NEG_ONE_EXT) && (cy_ext <= ONE_EXT);

  // Final hover update for the transaction
  always_comb begin
    hov_flag_nxt = hov_flag_r;
    hov_key_nxt  = hov_key_r;
    if (cmd.finish) begin
      unique case (act_r)
        ACT_ADD: begin
          hov_flag_nxt = hov_flag_r;
        end
        ACT_REMOVE: begin
          if (removed_r && hov_flag_r && (hov_key_r == id_r)) begin
            hov_flag_nxt = 1'b0;
            hov_key_nxt  = '0;
          end
        end
        ACT_CLEAR: begin
          hov_flag_nxt = 1'b0;
          hov_key_nxt  = '0;
        end
        ACT_TICK: begin
          if (focus_r) begin
            hov_flag_nxt = in_range && found_r;
            hov_key_nxt  = (in_range && found_r) ? best_key_r : '0;
          end
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= '0;
      slots_used_r <= '0;
      stk_cnt_r    <= '0;
      next_prio_r  <= '0;
      hov_flag_r   <= 1'b0;
      hov_key_r    <= '0;
      scan_idx_r   <= '0;
      cmp_valid_r  <= 1'b0;
      found_r      <= 1'b0;
      removed_r    <= 1'b0;
      rej_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      hov_flag_r <= hov_flag_nxt;
      hov_key_r  <= hov_key_nxt;
      if (cmd.accept) begin
        scan_idx_r  <= '0;
        cmp_valid_r <= 1'b0;
        found_r     <= 1'b0;
        removed_r   <= 1'b0;
        rej_r       <= 1'b0;
      end
      // store or reject the add
      if (cmd.add_write) begin
        if (table_full) begin
          rej_r <= 1'b1;
        end else begin
          active_r[add_slot] <= 1'b1;
          next_prio_r        <= next_prio_r + PRIORITY_BITS'(1);
          if (stack_empty) begin
            slots_used_r <= slots_used_r + CNT_W'(1);
          end else begin
            stk_cnt_r <= stk_cnt_r - CNT_W'(1);
          end
        end
      end
      // advance the scan
      if (cmd.scan_step) begin
        cmp_valid_r <= issue;
        if (issue) begin
          scan_idx_r <= scan_idx_r + CNT_W'(1);
        end
      end
      if (rm_hit) begin
        active_r[cmp_idx_r] <= 1'b0;
        removed_r           <= 1'b1;
        if (stk_we) begin
          stk_cnt_r <= stk_cnt_r + CNT_W'(1);
        end
      end
      if (hit) begin
        found_r <= 1'b1;
      end
      // drop the whole table on clear
      if (cmd.finish && (act_r == ACT_CLEAR)) begin
        active_r     <= '0;
        slots_used_r <= '0;
        stk_cnt_r    <= '0;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Scan and result payload
  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      cmp_idx_r <= scan_idx_r[SLOT_W-1:0];
    end
    if (hit) begin
      best_prio_r <= ent_rd_r.prio;
      best_key_r  <= ent_rd_r.key;
    end
    if (cmd.finish) begin
      out_hover_valid_r  <= hov_flag_nxt;
      out_hover_id_r     <= hov_key_nxt;
      out_add_rejected_r <= rej_r;
    end
  end

  assign sts.scan_done = cmp_valid_r && (cmp_idx_r == LAST_SLOT);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_hover_valid  = out_hover_valid_r;
  assign out_hover_id     = out_hover_id_r;
  assign out_add_rejected = out_add_rejected_r;

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the priority rectangle hit table.
module testbench;
  import prht_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int QUIET_LIMIT = 5000;
  localparam int TAIL_CYCLES = 40;
  localparam int ITEM_TARGET = 1100;

  typedef struct {
    prht_action_t       act;
    logic [7:0]         id;
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] width;
    logic signed [15:0] height;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic               focus;
  } hit_req_t;

  typedef struct {
    logic       hover_valid;
    logic [7:0] hover_id;
    logic       add_rejected;
  } hit_resp_t;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] right;
    logic signed [15:0] bottom;
    logic [31:0]        prio;
    logic [7:0]         key;
    bit                 active;
  } rect_entry_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  prht_in_if  #(.KEY_BITS(8), .COORD_BITS(16)) in_ch ();
  prht_out_if #(.KEY_BITS(8))                  out_ch ();

  priority_rect_hit_table i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  // Shadow copy of the table and hover register
  rect_entry_t rect_tab [TABLE_DEPTH];
  int          slots_issued = 0;
  int          free_slots [$];
  logic [31:0] prio_next = '0;
  bit          hov_on = 1'b0;
  logic [7:0]  hov_key = '0;

  hit_req_t  pending_reqs [$];
  hit_resp_t hover_due [$];
  int        req_total = 0;
  int        items_taken = 0;
  int        mismatches = 0;
  int        quiet_cycles = 0;
  logic      in_fire = 1'b0;
  int        gap_left = 0;
  int        stall_left = 0;
  bit        calm = 1'b0;
  int        near_x [2] = '{0, 0};
  int        near_y [2] = '{0, 0};

  function automatic logic signed [15:0] clip_coord(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return 16'(v);
  endfunction

  // Apply one transaction to the shadow table and return the result it produces
  function automatic hit_resp_t apply_action(hit_req_t r);
    hit_resp_t   res;
    int          slot;
    int          x;
    int          y;
    bit          found;
    bit          removed;
    logic [31:0] best;
    logic [7:0]  best_key;
    res.add_rejected = 1'b0;
    case (r.act)
      ACT_ADD: begin
        slot = -1;
        if (free_slots.size() != 0) begin
          slot = free_slots.pop_back();
        end else if (slots_issued < TABLE_DEPTH) begin
          slot = slots_issued;
          slots_issued++;
        end
        if (slot < 0) begin
          res.add_rejected = 1'b1;
        end else begin
          rect_tab[slot].left   = r.left;
          rect_tab[slot].top    = r.top;
          rect_tab[slot].right  = clip_coord(int'(r.left) + int'(r.width));
          rect_tab[slot].bottom = clip_coord(int'(r.top) - int'(r.height));
          rect_tab[slot].prio   = prio_next;
          rect_tab[slot].key    = r.id;
          rect_tab[slot].active = 1'b1;
          prio_next++;
        end
      end
      ACT_REMOVE: begin
        removed = 1'b0;
        // release matching slots in ascending order
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (rect_tab[i].active && rect_tab[i].key == r.id) begin
            rect_tab[i].active = 1'b0;
            if (free_slots.size() < TABLE_DEPTH) free_slots.push_back(i);
            removed = 1'b1;
          end
        end
        if (removed && hov_on && hov_key == r.id) begin
          hov_on  = 1'b0;
          hov_key = '0;
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < TABLE_DEPTH; i++) rect_tab[i].active = 1'b0;
        slots_issued = 0;
        free_slots.delete();
        hov_on  = 1'b0;
        hov_key = '0;
      end
      default: begin
        // unfocused ticks keep the hover as it is
        if (r.focus) begin
          x = r.cx;
          y = r.cy;
          hov_on  = 1'b0;
          hov_key = '0;
          if (x >= -ONE_Q12 && x <= ONE_Q12 && y >= -ONE_Q12 && y <= ONE_Q12) begin
            found    = 1'b0;
            best     = '0;
            best_key = '0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
              if (rect_tab[i].active && rect_tab[i].key != 0 &&
                  x >= rect_tab[i].left && x <= rect_tab[i].right &&
                  y <= rect_tab[i].top && y >= rect_tab[i].bottom &&
                  (!found || rect_tab[i].prio > best)) begin
                found    = 1'b1;
                best     = rect_tab[i].prio;
                best_key = rect_tab[i].key;
              end
            end
            hov_on  = found;
            hov_key = best_key;
          end
        end
      end
    endcase
    res.hover_valid = hov_on;
    res.hover_id    = hov_on ? hov_key : 8'd0;
    return res;
  endfunction

  // Idle length: mostly none or short, now and then long, with calm stretches
  function automatic int idle_len();
    int pick;
    if ($urandom_range(127) == 0) calm = !calm;
    if (calm) return 0;
    pick = $urandom_range(99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [15:0] pick_span(int lo, int hi);
    return 16'(lo + int'($urandom_range(hi - lo)));
  endfunction

  function automatic logic [7:0] pick_id();
    logic [7:0] pool [6] = '{8'd1, 8'd2, 8'd3, 8'd0, 8'd255, 8'd128};
    if ($urandom_range(7) == 0) return 8'($urandom);
    return pool[$urandom_range(5)];
  endfunction

  function automatic hit_req_t mk(prht_action_t a, int id, int l, int t, int w, int h,
                                  int cx, int cy, bit f);
    hit_req_t r;
    r.act    = a;
    r.id     = 8'(id);
    r.left   = 16'(l);
    r.top    = 16'(t);
    r.width  = 16'(w);
    r.height = 16'(h);
    r.cx     = 16'(cx);
    r.cy     = 16'(cy);
    r.focus  = f;
    return r;
  endfunction

  // Fully random fields; callers narrow what matters for the action
  function automatic hit_req_t blank_req(prht_action_t a);
    hit_req_t r;
    r.act    = a;
    r.id     = 8'($urandom);
    r.left   = 16'($urandom);
    r.top    = 16'($urandom);
    r.width  = 16'($urandom);
    r.height = 16'($urandom);
    r.cx     = 16'($urandom);
    r.cy     = 16'($urandom);
    r.focus  = 1'($urandom);
    return r;
  endfunction

  function automatic hit_req_t add_req();
    hit_req_t r = blank_req(ACT_ADD);
    r.id = pick_id();
    if ($urandom_range(9) != 0) begin
      r.left   = pick_span(-5000, 4200);
      r.width  = pick_span(0, 6000);
      r.top    = pick_span(-4200, 5000);
      r.height = pick_span(0, 6000);
    end
    near_x[0] = r.left;
    near_x[1] = int'(r.left) + int'(r.width);
    near_y[0] = r.top;
    near_y[1] = int'(r.top) - int'(r.height);
    return r;
  endfunction

  function automatic hit_req_t tick_req();
    hit_req_t r = blank_req(ACT_TICK);
    int       rim [4] = '{-4097, -4096, 4096, 4097};
    int       pick = $urandom_range(9);
    r.focus = ($urandom_range(7) != 0);
    if (pick == 1) begin
      r.cx = 16'(rim[$urandom_range(3)]);
      r.cy = 16'(rim[$urandom_range(3)]);
    end else if (pick == 2 || pick == 3) begin
      r.cx = 16'(near_x[$urandom_range(1)]);
      r.cy = 16'(near_y[$urandom_range(1)]);
    end else if (pick != 0) begin
      r.cx = pick_span(-4096, 4096);
      r.cy = pick_span(-4096, 4096);
    end
    return r;
  endfunction

  // Stimulus: directed opening, then scenes of adds followed by mixed traffic
  initial begin
    hit_req_t r;
    int       n;
    in_ch.valid          = 1'b0;
    in_ch.action         = ACT_TICK;
    in_ch.rect_id        = '0;
    in_ch.rect_left      = '0;
    in_ch.rect_top       = '0;
    in_ch.rect_width     = '0;
    in_ch.rect_height    = '0;
    in_ch.cursor_x       = '0;
    in_ch.cursor_y       = '0;
    in_ch.window_focused = 1'b0;
    out_ch.ready         = 1'b0;

    // empty table, unnamed entry that never hovers
    pending_reqs.push_back(mk(ACT_TICK,   0,      0,      0,      0,      0,     0,     0, 1));
    pending_reqs.push_back(mk(ACT_ADD,    0,  -8192,   8192,  16384,  16384,     0,     0, 1));
    pending_reqs.push_back(mk(ACT_TICK,   0,      0,      0,      0,      0,     0,     0, 1));
    pending_reqs.push_back(mk(ACT_ADD,    1,  -4096,   4096,   8192,   8192,     0,     0, 0));
    pending_reqs.push_back(mk(ACT_TICK,   0,      0,      0,      0,      0,     0,     0, 1));
    // right and bottom saturate; higher priority wins on the shared corner
    pending_reqs.push_back(mk(ACT_ADD,  255,   4096,  -4096,  32767,  32767,     0,     0, 1));
    pending_reqs.push_back(mk(ACT_TICK,   0,      0,      0,      0,      0,  4096, -4096, 1));
    pending_reqs.push_back(mk(ACT_TICK,   0,      0,      0,      0,      0, 30000, 30000, 0));
    pending_reqs.push_back(mk(ACT_TICK,   0,      0,      0,      0,      0,  4097, -4096, 1));
    pending_reqs.push_back(mk(ACT_TICK,   0,      0,      0,      0,      0, -4096,  4096, 1));
    // removal: absent key, unnamed entries, then the hovered key
    pending_reqs.push_back(mk(ACT_REMOVE, 2,      0,      0,      0,      0,     0,     0, 1));
    pending_reqs.push_back(mk(ACT_REMOVE, 0,      0,      0,      0,      0,     0,     0, 1));
    pending_reqs.push_back(mk(ACT_REMOVE, 1,      0,      0,      0,      0,     0,     0, 1));
    // extreme edges into recycled slots
    pending_reqs.push_back(mk(ACT_ADD,    7, -32768,  32767, -32768, -32768,     0,     0, 1));
    pending_reqs.push_back(mk(ACT_ADD,  128,      0,      0,      0,      0,     0,     0, 1));
    pending_reqs.push_back(mk(ACT_TICK,   0,      0,      0,      0,      0,     0,     0, 1));
    pending_reqs.push_back(mk(ACT_TICK,   0,      0,      0,      0,      0,-32768, 32767, 1));
    pending_reqs.push_back(mk(ACT_TICK,   0,      0,      0,      0,      0,     0,     0, 1));
    pending_reqs.push_back(mk(ACT_CLEAR,  0,      0,      0,      0,      0,     0,     0, 1));
    pending_reqs.push_back(mk(ACT_TICK,   0,      0,      0,      0,      0,     0,     0, 1));

    while (pending_reqs.size() < ITEM_TARGET) begin
      if ($urandom_range(3) == 0) pending_reqs.push_back(blank_req(ACT_CLEAR));
      // burst of adds, long enough at times to fill the table
      n = $urandom_range(1, 20);
      repeat (n) begin
        pending_reqs.push_back(add_req());
        if ($urandom_range(2) == 0) pending_reqs.push_back(tick_req());
      end
      n = $urandom_range(5, 30);
      repeat (n) begin
        case ($urandom_range(9))
          0, 1: r = add_req();
          2, 3: begin
            r    = blank_req(ACT_REMOVE);
            r.id = pick_id();
          end
          4: r = blank_req(prht_action_t'($urandom_range(3)));
          default: r = tick_req();
        endcase
        pending_reqs.push_back(r);
      end
    end
    req_total = pending_reqs.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // drain, then let the tail run for stray results
    while (items_taken < req_total || hover_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && hover_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Input driver: hold until accepted, then idle or launch the next transaction
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_fire) begin
      // hold the offered transaction
    end else if (gap_left > 0) begin
      in_ch.valid <= 1'b0;
      gap_left--;
    end else if (pending_reqs.size() != 0) begin
      in_ch.action         <= pending_reqs[0].act;
      in_ch.rect_id        <= pending_reqs[0].id;
      in_ch.rect_left      <= pending_reqs[0].left;
      in_ch.rect_top       <= pending_reqs[0].top;
      in_ch.rect_width     <= pending_reqs[0].width;
      in_ch.rect_height    <= pending_reqs[0].height;
      in_ch.cursor_x       <= pending_reqs[0].cx;
      in_ch.cursor_y       <= pending_reqs[0].cy;
      in_ch.window_focused <= pending_reqs[0].focus;
      in_ch.valid          <= 1'b1;
      void'(pending_reqs.pop_front());
      gap_left = idle_len();
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Result back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(3) == 0) stall_left = idle_len();
    end
  end

  // Monitor: check results against the oldest expectation, predict on acceptance
  always @(posedge clk) begin : monitor
    hit_resp_t want;
    hit_req_t  got;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_ch.valid && in_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        if (hover_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: valid=%0d id=%0d rej=%0d",
                     out_ch.hover_valid, out_ch.hover_id, out_ch.add_rejected);
        end else begin
          want = hover_due.pop_front();
          if (out_ch.hover_valid !== want.hover_valid || out_ch.hover_id !== want.hover_id ||
              out_ch.add_rejected !== want.add_rejected) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: want valid=%0d id=%0d rej=%0d, got valid=%0d id=%0d rej=%0d",
                       want.hover_valid, want.hover_id, want.add_rejected,
                       out_ch.hover_valid, out_ch.hover_id, out_ch.add_rejected);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        got.act    = prht_action_t'(in_ch.action);
        got.id     = in_ch.rect_id;
        got.left   = in_ch.rect_left;
        got.top    = in_ch.rect_top;
        got.width  = in_ch.rect_width;
        got.height = in_ch.rect_height;
        got.cx     = in_ch.cursor_x;
        got.cy     = in_ch.cursor_y;
        got.focus  = in_ch.window_focused;
        hover_due.push_back(apply_action(got));
        items_taken++;
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule

// ----- filelist.f -----
hw/rtl/prht_pkg.sv
hw/rtl/prht_if.sv
hw/rtl/prht_ctrl.sv
hw/rtl/prht_dp.sv
hw/rtl/priority_rect_hit_table.sv
bench/testbench.sv
